// ===== rtl/core/pbrr_pkg.sv =====
// Shared types and constants for the PE base-relocation reverter.
// Used by pbrr_step and pe_base_reloc_revert. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbrr_pkg;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned OFS_W    = 12;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ADJ_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W    = 104;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_ADJ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SIZE   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_PAST_DIR  = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd4;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_HIGH = 3'd1;
  localparam logic [2:0] KIND_LOW  = 3'd2;
  localparam logic [2:0] KIND_HL32 = 3'd3;
  localparam logic [2:0] KIND_D64  = 3'd4;

  localparam logic [3:0] RT_ABSOLUTE = 4'd0;
  localparam logic [3:0] RT_HIGH     = 4'd1;
  localparam logic [3:0] RT_LOW      = 4'd2;
  localparam logic [3:0] RT_HIGHLOW  = 4'd3;
  localparam logic [3:0] RT_DIR64    = 4'd10;

  localparam logic [ADDR_W-1:0] HDR_BYTES = 32'd8;

  typedef enum logic [4:0] {
    PH_PAGE_LO = 5'b00001,
    PH_PAGE_HI = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_LEN_HI  = 5'b01000,
    PH_ENTRY   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] page;
    logic [ADDR_W-1:0] bytes_left;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] consumed;
    logic [2:0]        status;
  } run_state_t;

  // Packed lowest field last, so fixup_valid lands in bit 0.
  typedef struct packed {
    logic             directory_done;
    logic [2:0]       status;
    logic [ADJ_W-1:0] subtract_amount;
    logic [2:0]       fixup_kind;
    logic [ADDR_W-1:0] fixup_offset;
    logic             fixup_valid;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] image_size;
    logic [ADJ_W-1:0]  load_adjust;
    logic [ADDR_W-1:0] dir_size;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pe_base_reloc_revert.sv =====
// PE base-relocation reverter: takes one directory halfword per clock and
// returns one fixup/status transaction for each. Depends on pbrr_pkg, pbrr_step.
// The result is registered in the cycle after its input is accepted; the
// only holdup is the result register when out_tready is low. State is a single
// set of run registers updated at each input transaction; a halfword with
// in_tuser set restarts the directory before it is used. Errors are sticky.
`timescale 1ns / 1ps
`default_nettype none

module pe_base_reloc_revert
  import pbrr_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr,
  input  wire  [ADJ_W-1:0]      cfg_wdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [HALF_W-1:0]     in_tdata,   // [15:0] dir_half
  input  wire                   in_tuser,   // [0] first_half
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // [0] fixup_valid, [32:1] fixup_offset, [35:33] fixup_kind,
  // [99:36] subtract_amount, [102:100] status, [103] directory_done
  output logic [OUT_W-1:0]      out_tdata
);

  cfg_t       cfg_r;
  run_state_t st_r, st_nxt;
  result_t    res_nxt, res_r;
  logic       out_vld_r;
  logic       in_acc;

  assign in_tready  = !out_vld_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;

  pbrr_step u_step (
    .cur   (st_r),
    .cfg   (cfg_r),
    .half  (in_tdata),
    .first (in_tuser),
    .nxt   (st_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_SIZE: cfg_r.image_size  <= cfg_wdata[ADDR_W-1:0];
        REG_LOAD_ADJ:   cfg_r.load_adjust <= cfg_wdata;
        REG_DIR_SIZE:   cfg_r.dir_size    <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{phase: PH_PAGE_LO, default: '0};
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) st_r <= st_nxt;
      if (in_acc) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.status != ST_OK && !(in_acc && in_tuser)) |=> $stable(st_r))
    else $error("sticky error state changed without restart");

  a_fixup_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.fixup_valid) |-> (res_r.status == ST_OK))
    else $error("fixup issued alongside error");

  a_hdr_nofix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && st_r.phase != PH_ENTRY) |=> !res_r.fixup_valid)
    else $error("fixup issued from a header halfword");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status != ST_OK) |-> res_r.directory_done)
    else $error("error reported without done");

endmodule

`default_nettype wire

// ===== rtl/core/pbrr_step.sv =====
// Next-state and result logic for one directory halfword.
// Purely combinational; depends on pbrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbrr_step
  import pbrr_pkg::*;
(
  input  var run_state_t        cur,
  input  var cfg_t              cfg,
  input  wire  [HALF_W-1:0]     half,
  input  wire                   first,
  output run_state_t            nxt,
  output result_t               res
);

  run_state_t        s;
  logic [ADDR_W:0]   cons_sum;
  logic [ADDR_W-1:0] cons_inc;
  logic [ADDR_W-1:0] len_full;
  logic [ADDR_W-1:0] blk_start;
  logic [ADDR_W:0]   blk_end;
  logic [ADDR_W:0]   ent_ofs;
  logic [3:0]        rtype;
  logic [2:0]        kind;
  logic [ADJ_W-1:0]  amount;
  logic [ADDR_W:0]   done_cmp;
  logic              can_start;

  always_comb begin
    s = first ? run_state_t'{phase: PH_PAGE_LO, default: '0} : cur;
    cons_sum  = {1'b0, s.consumed} + 33'd2;
    cons_inc  = cons_sum[ADDR_W] ? '1 : cons_sum[ADDR_W-1:0];
    can_start = ({1'b0, s.consumed} + 33'd1) < {1'b0, cfg.dir_size};
    len_full  = {half, s.length[HALF_W-1:0]};
    blk_start = (cons_inc >= HDR_BYTES) ? (cons_inc - HDR_BYTES) : '0;
    blk_end   = {1'b0, blk_start} + {1'b0, len_full};
    ent_ofs   = {1'b0, s.page} + {{(ADDR_W+1-OFS_W){1'b0}}, half[OFS_W-1:0]};
    rtype     = half[HALF_W-1:HALF_W-4];
    kind      = KIND_NONE;
    amount    = '0;
    nxt       = s;
    res       = '0;

    if (s.status == ST_OK) begin
      unique case (s.phase)
        PH_PAGE_LO: begin
          if (can_start) begin
            nxt.page     = {{(ADDR_W-HALF_W){1'b0}}, half};
            nxt.phase    = PH_PAGE_HI;
            nxt.consumed = cons_inc;
          end
        end
        PH_PAGE_HI: begin
          nxt.page     = {half, s.page[HALF_W-1:0]};
          nxt.phase    = PH_LEN_LO;
          nxt.consumed = cons_inc;
        end
        PH_LEN_LO: begin
          nxt.length   = {{(ADDR_W-HALF_W){1'b0}}, half};
          nxt.phase    = PH_LEN_HI;
          nxt.consumed = cons_inc;
        end
        PH_LEN_HI: begin
          nxt.length   = len_full;
          nxt.consumed = cons_inc;
          nxt.phase    = PH_PAGE_LO;
          if (len_full < HDR_BYTES || len_full[0]) begin
            nxt.status = ST_BAD_SIZE;
          end else if (blk_end > {1'b0, cfg.dir_size}) begin
            nxt.status = ST_PAST_DIR;
          end else if (s.page >= cfg.image_size) begin
            nxt.status = ST_OUTSIDE;
          end else begin
            nxt.bytes_left = len_full - HDR_BYTES;
            if (len_full != HDR_BYTES) nxt.phase = PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          nxt.consumed = cons_inc;
          if (ent_ofs >= {1'b0, cfg.image_size}) begin
            nxt.status = ST_OUTSIDE;
          end else begin
            priority case (rtype)
              RT_ABSOLUTE: kind = KIND_NONE;
              RT_HIGH: begin
                kind   = KIND_HIGH;
                amount = {48'd0, cfg.load_adjust[31:16]};
              end
              RT_LOW: begin
                kind   = KIND_LOW;
                amount = {48'd0, cfg.load_adjust[15:0]};
              end
              RT_HIGHLOW: begin
                kind   = KIND_HL32;
                amount = {32'd0, cfg.load_adjust[31:0]};
              end
              RT_DIR64: begin
                kind   = KIND_D64;
                amount = cfg.load_adjust;
              end
              default: nxt.status = ST_BAD_TYPE;
            endcase
          end
          if (nxt.status == ST_OK && kind != KIND_NONE) begin
            res.fixup_valid     = 1'b1;
            res.fixup_offset    = ent_ofs[ADDR_W-1:0];
            res.fixup_kind      = kind;
            res.subtract_amount = amount;
          end
          if (nxt.status != ST_OK) begin
            nxt.phase = PH_PAGE_LO;
          end else begin
            nxt.bytes_left = (s.bytes_left >= 32'd2) ? (s.bytes_left - 32'd2) : '0;
            if (nxt.bytes_left == '0) nxt.phase = PH_PAGE_LO;
          end
        end
        default: nxt = s;
      endcase
    end

    done_cmp           = {1'b0, nxt.consumed} + 33'd1;
    res.status         = nxt.status;
    res.directory_done = (nxt.status != ST_OK) ||
                         (nxt.phase == PH_PAGE_LO && done_cmp >= {1'b0, cfg.dir_size});
  end

endmodule

`default_nettype wire
